// ===== src/pba_pkg.sv =====
// Shared types and constants for the page bitmap allocator.
package pba_pkg;

  // Map geometry
  localparam int PAGE_COUNT  = 4096;
  localparam int PAGE_SHIFT  = 12;
  localparam int MAP_WORDS   = (PAGE_COUNT + 31) / 32;
  localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PAGE_IDX_W  = WORD_IDX_W + 5;

  // Field widths
  localparam int ADDR_W      = 32;
  localparam int CNT_W       = 13;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_PAGE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] page_address;
  } pba_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
  } pba_rsp_t;

endpackage

// ===== src/pba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/page_bitmap_allocator.sv =====
// Page bitmap allocator top level: request sequencer, bitmap RAM and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in_     | input     | in_valid/in_ready  | in_data   (kind, page_address)
//  out_    | output    | out_valid/out_ready| out_data  (granted_address, status)
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One request is in flight at a time. An allocate reads k bitmap words in turn,
// until a free page turns up or the range runs out (1 <= k <= 128): the RAM read
// port delivers one word a cycle. A free reads one word and writes it back, and
// an out-of-range free or an allocate with no pages answers without the RAM.
// Reset marks every page used through per-word valid bits; no clearing pass.
// A stalled result holds in the output register while the next request is
// accepted; that request waits for the register before it finishes.
module page_bitmap_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pba_pkg::pba_req_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pba_pkg::pba_rsp_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [pba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pba_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import pba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  // configuration
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  pages_r;
  logic [CNT_W-1:0]  act_cnt;

  // sequencer
  logic [1:0]            state_r, state_nxt;
  logic [WORD_IDX_W-1:0] word_r, word_nxt;
  logic [4:0]            bit_r, bit_nxt;
  logic [STATUS_W-1:0]   pend_r, pend_nxt;

  // bitmap RAM and per-word valid bits
  logic                  ram_we, ram_re;
  logic [WORD_IDX_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]           ram_wdata, ram_rdata;
  logic [MAP_WORDS-1:0]  word_vld_r;
  logic                  rd_vld_r;
  logic [31:0]           rd_word;

  // result register
  logic        out_valid_r;
  pba_rsp_t    out_data_r;
  logic        slot_free;
  logic        emit;
  logic [ADDR_W-1:0]   emit_addr;
  logic [STATUS_W-1:0] emit_status;

  // request decode
  logic              in_acc;
  logic [ADDR_W-1:0] free_off;
  logic [ADDR_W-1:0] free_idx;
  logic              free_ok;

  // scan datapath
  logic [31:0]           first_pg;
  logic [31:0]           next_pg;
  logic                  word_full;
  logic [4:0]            rem;
  logic [31:0]           pg_mask;
  logic [31:0]           free_bits;
  logic [31:0]           hit_bit;
  logic [4:0]            hit_pos;
  logic [PAGE_IDX_W-1:0] hit_page;

  pba_ram #(
    .WIDTH (32),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pages_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ADDRESS: base_r  <= cfg_wdata;
        CFG_PAGES_IN_USE: pages_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // active page count saturates at the map size
  assign act_cnt = (32'(pages_r) > 32'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT) : pages_r;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // address to page index for frees
  assign free_off = in_data.page_address - base_r;
  assign free_idx = free_off >> PAGE_SHIFT;
  assign free_ok  = free_idx < 32'(act_cnt);

  // unwritten words read as all used
  assign rd_word = rd_vld_r ? ram_rdata : '1;

  // pages of the current word that lie below the active count
  assign first_pg  = 32'(word_r) << 5;
  assign next_pg   = first_pg + 32'd32;
  assign word_full = 32'(act_cnt) >= next_pg;
  assign rem       = 5'(32'(act_cnt) - first_pg);
  assign pg_mask   = word_full ? '1 : ~({32{1'b1}} << rem);
  assign free_bits = ~rd_word & pg_mask;
  assign hit_bit   = free_bits & (~free_bits + 32'd1);

  // lowest free bit position
  always_comb begin
    hit_pos = '0;
    for (int i = 31; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_pos = 5'(i);
      end
    end
  end

  assign hit_page = {word_r, hit_pos};

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    word_nxt    = word_r;
    bit_nxt     = bit_r;
    pend_nxt    = pend_r;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    ram_we      = 1'b0;
    ram_waddr   = word_r;
    ram_wdata   = rd_word;
    emit        = 1'b0;
    emit_addr   = '0;
    emit_status = STATUS_DONE;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == KIND_ALLOC) begin
            if (act_cnt != '0) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              word_nxt  = '0;
              state_nxt = S_SCAN;
            end else begin
              pend_nxt  = STATUS_NO_PAGE;
              state_nxt = S_RESP;
            end
          end else if (free_ok) begin
            ram_re    = 1'b1;
            ram_raddr = free_idx[PAGE_IDX_W-1:5];
            word_nxt  = free_idx[PAGE_IDX_W-1:5];
            bit_nxt   = free_idx[4:0];
            state_nxt = S_FREE;
          end else begin
            pend_nxt  = STATUS_RANGE;
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          // claim the page once the result register can take it
          if (slot_free) begin
            ram_we      = 1'b1;
            ram_wdata   = rd_word | hit_bit;
            emit        = 1'b1;
            emit_addr   = base_r + (32'(hit_page) << PAGE_SHIFT);
            emit_status = STATUS_DONE;
            state_nxt   = S_IDLE;
          end
        end else if (!word_full || next_pg == 32'(act_cnt)) begin
          // last word in range and nothing free
          if (slot_free) begin
            emit        = 1'b1;
            emit_status = STATUS_NO_PAGE;
            state_nxt   = S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = word_r + WORD_IDX_W'(1);
          word_nxt  = word_r + WORD_IDX_W'(1);
        end
      end
      S_FREE: begin
        if (slot_free) begin
          ram_we      = 1'b1;
          ram_wdata   = rd_word & ~(32'd1 << bit_r);
          emit        = 1'b1;
          emit_status = STATUS_DONE;
          state_nxt   = S_IDLE;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_status = pend_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      word_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        word_vld_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    bit_r  <= bit_nxt;
    pend_r <= pend_nxt;
    if (ram_re) begin
      rd_vld_r <= word_vld_r[ram_raddr];
    end
    if (emit) begin
      out_data_r.granted_address <= emit_addr;
      out_data_r.status          <= emit_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("result emitted into a busy output register");

  // the RAM is never read and written back in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_re && ram_we))
    else $error("bitmap read and write overlap");

  // only a granted page carries a non-zero address
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_status != STATUS_DONE) |-> (emit_addr == '0))
    else $error("failed request carries an address");

  // a bitmap write always finishes the request
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == S_IDLE && out_valid_r))
    else $error("bitmap write without a result");

endmodule

// ===== tb/page_bitmap_allocator_tb.sv =====
// Self-checking testbench for the page bitmap allocator, with its own bitmap predictor.
`timescale 1ns / 100ps

module page_bitmap_allocator_tb;
  import pba_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int IDLE_PCT       = 78;
  localparam int BOTH_PCT       = 13;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pba_req_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pba_rsp_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE_ADDRESS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  page_bitmap_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: page bitmap and register copies
  logic [PAGE_COUNT-1:0] page_used;
  logic [ADDR_W-1:0]     map_base;
  logic [CNT_W-1:0]      map_pages;

  pba_req_t pending_reqs[$];
  pba_rsp_t rsp_expected[$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  bit in_taken           = 1'b0;
  int fail_count         = 0;
  int idle_cycles        = 0;
  int n_items            = 0;
  int n_results          = 0;
  int n_grants           = 0;
  int n_no_page          = 0;
  int n_range            = 0;
  int n_phases           = 0;

  always #CLK_HALF clk = ~clk;

  // Page count after saturation
  function automatic int active_pages();
    return (map_pages > PAGE_COUNT) ? PAGE_COUNT : int'(map_pages);
  endfunction

  // First-fit allocate or free against the bitmap copy
  function automatic pba_rsp_t predict_request(pba_req_t req);
    pba_rsp_t          rsp;
    int                count;
    bit                found;
    logic [ADDR_W-1:0] page_idx;
    count = active_pages();
    rsp   = '0;
    found = 1'b0;
    if (req.kind == KIND_ALLOC) begin
      rsp.status = STATUS_NO_PAGE;
      for (int i = 0; i < count; i++) begin
        if (!found && !page_used[i]) begin
          found              = 1'b1;
          page_used[i]       = 1'b1;
          page_idx           = i;
          rsp.granted_address = map_base + (page_idx << PAGE_SHIFT);
          rsp.status         = STATUS_DONE;
        end
      end
    end else begin
      // offset wraps at 32 bits before the shift
      page_idx = (req.page_address - map_base) >> PAGE_SHIFT;
      if (page_idx < ADDR_W'(count)) begin
        page_used[page_idx] = 1'b0;
        rsp.status = STATUS_DONE;
      end else begin
        rsp.status = STATUS_RANGE;
      end
    end
    return rsp;
  endfunction

  // Random junk above the 13 bits that the page count register keeps
  function automatic logic [CFG_DATA_W-1:0] junk_hi(int value);
    return ($urandom & ~32'h1FFF) | (value & 32'h1FFF);
  endfunction

  task automatic queue_req(logic kind, logic [ADDR_W-1:0] addr);
    pba_req_t req;
    req.kind         = kind;
    req.page_address = addr;
    pending_reqs.push_back(req);
  endtask

  // Register write while the block is idle; predictor copy follows
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) map_base = value;
    else map_pages = value[CNT_W-1:0];
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || rsp_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly in-range frees and allocates, some edge and stray frees
  task automatic queue_random(int n);
    int                count;
    int                pick;
    int                idx;
    logic [ADDR_W-1:0] addr;
    for (int k = 0; k < n; k++) begin
      count = active_pages();
      pick  = $urandom_range(99);
      addr  = $urandom;
      if (pick < 40) begin
        queue_req(KIND_ALLOC, addr);
      end else if (pick < 85 && count > 0) begin
        idx = $urandom_range(count - 1);
        queue_req(KIND_FREE, map_base + (idx << PAGE_SHIFT) + $urandom_range(4095));
      end else if (pick < 95) begin
        idx = count + $urandom_range(7);
        queue_req(KIND_FREE, map_base + (idx << PAGE_SHIFT) + $urandom_range(4095));
      end else begin
        queue_req(KIND_FREE, addr);
      end
    end
  endtask

  task automatic run_phase(logic [ADDR_W-1:0] base, logic [CFG_DATA_W-1:0] pages,
                           int send_pct, int recv_pct, int n);
    wait_idle();
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_PAGES_IN_USE, pages);
    sender_idle_pct    = send_pct;
    receiver_stall_pct = recv_pct;
    n_phases++;
    queue_random(n);
  endtask

  // Request driver: next beat from the pending queue, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
  end

  // Monitor: check result beats, predict on request beats, watchdog
  always @(posedge clk) begin : monitor
    pba_rsp_t want;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        n_results++;
        if (rsp_expected.size() == 0) begin
          $display("%0t: result beat with nothing expected, got address %h status %0d",
                   $time, out_data.granted_address, out_data.status);
          fail_count++;
        end else begin
          want = rsp_expected.pop_front();
          if (out_data.granted_address !== want.granted_address) begin
            $display("%0t: granted_address mismatch, expected %h, got %h",
                     $time, want.granted_address, out_data.granted_address);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data.status);
            fail_count++;
          end
          if (want.status == STATUS_NO_PAGE) n_no_page++;
          else if (want.status == STATUS_RANGE) n_range++;
          else if (want.granted_address != '0 || want.status == STATUS_DONE) n_grants++;
        end
      end
      if (in_valid && in_ready) begin
        n_items++;
        rsp_expected.push_back(predict_request(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    page_used = '1;
    map_base  = '0;
    map_pages = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero page count: allocate has no page, any free is out of range
    write_reg(CFG_BASE_ADDRESS, 32'h0);
    write_reg(CFG_PAGES_IN_USE, 32'h0);
    n_phases++;
    queue_req(KIND_ALLOC, 32'hFFFF_FFFF);
    queue_req(KIND_FREE, 32'h0000_0000);
    queue_req(KIND_FREE, 32'hFFFF_FFFF);
    wait_idle();

    // 40 pages at base zero: map full after reset, zero grant, double free, edge
    write_reg(CFG_PAGES_IN_USE, 32'd40);
    n_phases++;
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_FREE, 32'h0000_0000);
    queue_req(KIND_ALLOC, 32'h0);             // page 0 granted as address zero
    queue_req(KIND_FREE, 32'h0002_7FFF);      // page 39, offset bits set
    queue_req(KIND_FREE, 32'h0002_7000);      // page 39 already free
    queue_req(KIND_FREE, 32'h0002_8000);      // page 40, just past the end
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_FREE, 32'h0000_6000);
    queue_req(KIND_FREE, 32'h0000_5000);
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);
    wait_idle();

    // Top base with saturated count: grants and frees wrap at 32 bits
    write_reg(CFG_BASE_ADDRESS, 32'hFFFF_F000);
    write_reg(CFG_PAGES_IN_USE, 32'hFFFF_FFFF);
    n_phases++;
    queue_req(KIND_FREE, 32'h00FF_E000);      // last page
    queue_req(KIND_FREE, 32'hFFFF_F000);      // page 0
    queue_req(KIND_FREE, 32'h00FF_F000);      // one past the last page
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);
    queue_req(KIND_ALLOC, 32'h0);             // full scan, nothing free
    queue_req(KIND_FREE, 32'h0000_0000);      // page 1
    queue_req(KIND_ALLOC, 32'h0);             // wraps to address zero

    // Random phases over several settings and idling patterns
    run_phase($urandom, junk_hi(PAGE_COUNT), 0, 0, 60);
    run_phase(32'h0, junk_hi(1), IDLE_PCT, 0, 60);
    run_phase($urandom, junk_hi($urandom_range(300, 32)), 0, IDLE_PCT, 60);
    run_phase(32'hFFFF_F000, junk_hi(13'h1FFF), BOTH_PCT, BOTH_PCT, 60);
    run_phase($urandom, junk_hi(0), 0, 0, 12);
    run_phase($urandom, junk_hi($urandom_range(64, 1)), IDLE_PCT, 0, 60);
    run_phase($urandom, junk_hi(PAGE_COUNT), 0, IDLE_PCT, 60);
    run_phase(32'h0, junk_hi($urandom_range(PAGE_COUNT, 32)), BOTH_PCT, BOTH_PCT, 60);
    wait_idle();

    $display("ran %0d requests over %0d register settings, %0d results checked",
             n_items, n_phases, n_results);
    $display("results: %0d done, %0d no free page, %0d free out of range, %0d errors",
             n_grants, n_no_page, n_range, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
